[rtl/mfts_pkg.sv]
package mfts_pkg;

    localparam int MAX_CORES_DEF  = 8;
    localparam int TASK_SLOTS_DEF = 64;
    localparam int QDEPTH         = 4;

    localparam logic [1:0] CMD_ADMIT  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    localparam logic [2:0] EV_DISPATCH = 3'd0;
    localparam logic [2:0] EV_FINISH   = 3'd1;
    localparam logic [2:0] EV_SLEEP    = 3'd2;
    localparam logic [2:0] EV_PREEMPT  = 3'd3;
    localparam logic [2:0] EV_CONTINUE = 3'd4;
    localparam logic [2:0] EV_ADMIT    = 3'd5;
    localparam logic [2:0] EV_FULL     = 3'd6;

    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_QUANTUM = 2'd1;
    localparam logic [1:0] REG_CORES   = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] task_id;
        logic [2:0] core_index;
        logic       task_done;
        logic       task_slept;
        logic [7:0] sleep_length;
    } cmd_t;

endpackage

[rtl/mfts_cmd_queue.sv]
module mfts_cmd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mfts_pkg::cmd_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mfts_pkg::cmd_t      out_data
);
    localparam int AW = $clog2(mfts_pkg::QDEPTH);

    mfts_pkg::cmd_t    mem [mfts_pkg::QDEPTH];
    logic [AW-1:0]     wr_reg;
    logic [AW-1:0]     rd_reg;
    logic [AW:0]       cnt_reg;

    assign in_ready  = (cnt_reg != (AW+1)'(mfts_pkg::QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_reg];

    // store beats
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem[wr_reg] <= in_data;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wr_reg <= wr_reg + AW'(1);
            end
            if (out_valid && out_ready)
            begin
                rd_reg <= rd_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(in_valid && in_ready)
                               - (AW+1)'(out_valid && out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rst_n && !$isunknown(cnt_reg))
        begin
            assert (cnt_reg <= (AW+1)'(mfts_pkg::QDEPTH))
                else $error("queue count overflow");
        end
    end

    property p_full_blocks;
        @(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(mfts_pkg::QDEPTH)) |-> !in_ready;
    endproperty
    a_full_blocks: assert property (p_full_blocks) else $error("full queue took beat");

    property p_count_step;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !(out_valid && out_ready)) |=>
            (cnt_reg == $past(cnt_reg) + (AW+1)'(1));
    endproperty
    a_count_step: assert property (p_count_step) else $error("count not advanced");

    property p_empty_invalid;
        @(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !out_valid;
    endproperty
    a_empty_invalid: assert property (p_empty_invalid) else $error("empty queue valid");

endmodule

[rtl/mfts_engine.sv]
module mfts_engine
#(
    parameter int MAX_CORES  = mfts_pkg::MAX_CORES_DEF,
    parameter int TASK_SLOTS = mfts_pkg::TASK_SLOTS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  mfts_pkg::cmd_t  cmd,
    input  logic            policy_mode,
    input  logic [7:0]      quantum_length,
    input  logic [3:0]      cores_in_use,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      event_kind,
    output logic [2:0]      event_core,
    output logic [5:0]      event_task,
    output logic [31:0]     executed_total,
    output logic            last_event
);
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLEEP_RD,
        S_SLEEP_WR,
        S_CORE,
        S_FIFO_RD,
        S_FIFO_WAIT,
        S_EMIT
    } state_t;

    state_t          state_reg;
    logic [5:0]      fifo_mem [TASK_SLOTS];
    logic [8:0]      sleep_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] sleep_ok_reg;
    logic [SW-1:0]   head_reg;
    logic [SW:0]     count_reg;
    logic [SW:0]     slot_reg;
    logic [8:0]      sleep_rd_reg;
    logic [5:0]      fifo_rd_reg;
    logic [MAX_CORES-1:0] cvalid_reg;
    logic [5:0]      ctask_reg [MAX_CORES];
    logic [7:0]      cquant_reg [MAX_CORES];
    logic [CW:0]     core_reg;
    logic [CW:0]     lim_reg;
    logic [31:0]     total_reg;
    logic [2:0]      kind_reg;
    logic [2:0]      ecore_reg;
    logic [5:0]      etask_reg;
    logic            last_reg;
    logic            tick_reg;
    logic            found_reg;

    logic [SW-1:0]   tail;
    logic [SW:0]     sum;
    logic            fifo_full;
    logic [7:0]      cnt_dec;
    logic [CW:0]     next_core;
    logic            more_free;
    logic [CW:0]     lim_calc;
    logic [CW-1:0]   rc;
    logic            rc_ok;
    logic [7:0]      qn;
    logic [7:0]      qlim;

    assign sum       = {1'b0, head_reg} + count_reg;
    assign tail      = (sum >= (SW+1)'(TASK_SLOTS)) ? SW'(sum - (SW+1)'(TASK_SLOTS))
                                                    : SW'(sum);
    assign fifo_full = (count_reg == (SW+1)'(TASK_SLOTS));
    assign cnt_dec   = (sleep_rd_reg[7:0] != 8'd0) ? sleep_rd_reg[7:0] - 8'd1 : 8'd0;
    assign rc        = CW'(cmd.core_index);
    assign rc_ok     = ({1'b0, cmd.core_index} < 4'(MAX_CORES));
    assign qn        = (cquant_reg[rc] != 8'hFF) ? cquant_reg[rc] + 8'd1 : 8'hFF;
    assign qlim      = (quantum_length == 8'd0) ? 8'd1 : quantum_length;
    assign lim_calc  = (cores_in_use == 4'd0) ? (CW+1)'(1)
                     : ({1'b0, cores_in_use} > 5'(MAX_CORES)) ? (CW+1)'(MAX_CORES)
                     : (CW+1)'(cores_in_use);
    assign cmd_ready = (state_reg == S_IDLE);

    assign out_valid      = (state_reg == S_EMIT);
    assign event_kind     = kind_reg;
    assign event_core     = ecore_reg;
    assign event_task     = etask_reg;
    assign executed_total = total_reg;
    assign last_event     = last_reg;

    // scan for the next free core from core_reg
    always_comb
    begin
        next_core = lim_reg;
        more_free = 1'b0;
        for (int c = MAX_CORES - 1; c >= 0; c--)
        begin
            if ((CW+1)'(c) >= core_reg && (CW+1)'(c) < lim_reg && !cvalid_reg[c])
            begin
                next_core = (CW+1)'(c);
                more_free = 1'b1;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SLEEP_RD)
        begin
            sleep_rd_reg <= sleep_mem[SW'(slot_reg)];
        end
        if (state_reg == S_SLEEP_WR && sleep_ok_reg[SW'(slot_reg)])
        begin
            sleep_mem[SW'(slot_reg)] <= {1'b1, cnt_dec};
        end
        if (state_reg == S_IDLE && cmd_valid && cmd.cmd == mfts_pkg::CMD_REPORT
            && rc_ok && cvalid_reg[rc] && !cmd.task_done && cmd.task_slept
            && {2'b0, ctask_reg[rc]} < 9'(TASK_SLOTS))
        begin
            sleep_mem[SW'(ctask_reg[rc])] <= {1'b1, cmd.sleep_length};
        end
        if (state_reg == S_FIFO_RD)
        begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
        if (!fifo_full)
        begin
            if (state_reg == S_IDLE && cmd_valid && cmd.cmd == mfts_pkg::CMD_ADMIT)
            begin
                fifo_mem[tail] <= cmd.task_id;
            end
            else if (state_reg == S_IDLE && cmd_valid && cmd.cmd == mfts_pkg::CMD_REPORT
                     && rc_ok && cvalid_reg[rc] && !cmd.task_done && !cmd.task_slept
                     && policy_mode && qn >= qlim)
            begin
                fifo_mem[tail] <= ctask_reg[rc];
            end
            else if (state_reg == S_SLEEP_WR && sleep_ok_reg[SW'(slot_reg)]
                     && cnt_dec == 8'd0)
            begin
                fifo_mem[tail] <= 6'(slot_reg);
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sleep_ok_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            slot_reg     <= '0;
            cvalid_reg   <= '0;
            core_reg     <= '0;
            lim_reg      <= '0;
            total_reg    <= '0;
            kind_reg     <= '0;
            ecore_reg    <= '0;
            etask_reg    <= '0;
            last_reg     <= 1'b0;
            tick_reg     <= 1'b0;
            found_reg    <= 1'b0;
            for (int c = 0; c < MAX_CORES; c++)
            begin
                ctask_reg[c]  <= '0;
                cquant_reg[c] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        tick_reg <= 1'b0;
                        last_reg <= 1'b1;
                        case (cmd.cmd)
                            mfts_pkg::CMD_ADMIT:
                            begin
                                ecore_reg <= '0;
                                etask_reg <= cmd.task_id;
                                kind_reg  <= fifo_full ? mfts_pkg::EV_FULL
                                                       : mfts_pkg::EV_ADMIT;
                                if (!fifo_full)
                                begin
                                    count_reg <= count_reg + (SW+1)'(1);
                                end
                                state_reg <= S_EMIT;
                            end
                            mfts_pkg::CMD_TICK:
                            begin
                                slot_reg  <= '0;
                                lim_reg   <= lim_calc;
                                found_reg <= 1'b0;
                                state_reg <= S_SLEEP_RD;
                            end
                            mfts_pkg::CMD_REPORT:
                            begin
                                if (rc_ok && cvalid_reg[rc])
                                begin
                                    total_reg <= total_reg + 32'd1;
                                    ecore_reg <= cmd.core_index;
                                    etask_reg <= ctask_reg[rc];
                                    state_reg <= S_EMIT;
                                    if (cmd.task_done)
                                    begin
                                        kind_reg       <= mfts_pkg::EV_FINISH;
                                        cvalid_reg[rc] <= 1'b0;
                                        cquant_reg[rc] <= '0;
                                    end
                                    else if (cmd.task_slept)
                                    begin
                                        kind_reg       <= mfts_pkg::EV_SLEEP;
                                        cvalid_reg[rc] <= 1'b0;
                                        cquant_reg[rc] <= '0;
                                        if ({2'b0, ctask_reg[rc]} < 9'(TASK_SLOTS))
                                        begin
                                            sleep_ok_reg[SW'(ctask_reg[rc])] <= 1'b1;
                                        end
                                    end
                                    else if (policy_mode && qn >= qlim)
                                    begin
                                        if (!fifo_full)
                                        begin
                                            kind_reg       <= mfts_pkg::EV_PREEMPT;
                                            cvalid_reg[rc] <= 1'b0;
                                            cquant_reg[rc] <= '0;
                                            count_reg      <= count_reg + (SW+1)'(1);
                                        end
                                        else
                                        begin
                                            kind_reg       <= mfts_pkg::EV_FULL;
                                            cquant_reg[rc] <= qn;
                                        end
                                    end
                                    else
                                    begin
                                        kind_reg       <= mfts_pkg::EV_CONTINUE;
                                        cquant_reg[rc] <= qn;
                                    end
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SLEEP_RD:
                begin
                    state_reg <= S_SLEEP_WR;
                end
                S_SLEEP_WR:
                begin
                    // wake or count down one slot
                    if (sleep_ok_reg[SW'(slot_reg)] && cnt_dec == 8'd0 && !fifo_full)
                    begin
                        sleep_ok_reg[SW'(slot_reg)] <= 1'b0;
                        count_reg <= count_reg + (SW+1)'(1);
                    end
                    slot_reg <= slot_reg + (SW+1)'(1);
                    if (slot_reg == (SW+1)'(TASK_SLOTS - 1))
                    begin
                        core_reg  <= '0;
                        state_reg <= S_CORE;
                    end
                    else
                    begin
                        state_reg <= S_SLEEP_RD;
                    end
                end
                S_CORE:
                begin
                    if (more_free && count_reg != '0)
                    begin
                        if (found_reg)
                        begin
                            // show the pending dispatch before the next one
                            tick_reg  <= 1'b1;
                            last_reg  <= 1'b0;
                            found_reg <= 1'b0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            core_reg  <= next_core;
                            state_reg <= S_FIFO_RD;
                        end
                    end
                    else if (found_reg)
                    begin
                        last_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FIFO_RD:
                begin
                    state_reg <= S_FIFO_WAIT;
                end
                S_FIFO_WAIT:
                begin
                    // dispatch to core_reg
                    cvalid_reg[CW'(core_reg)] <= 1'b1;
                    ctask_reg[CW'(core_reg)]  <= fifo_rd_reg;
                    cquant_reg[CW'(core_reg)] <= '0;
                    head_reg  <= (head_reg == SW'(TASK_SLOTS - 1)) ? '0 : head_reg + SW'(1);
                    count_reg <= count_reg - (SW+1)'(1);
                    found_reg <= 1'b1;
                    kind_reg  <= mfts_pkg::EV_DISPATCH;
                    ecore_reg <= 3'(core_reg);
                    etask_reg <= fifo_rd_reg;
                    core_reg  <= core_reg + (CW+1)'(1);
                    state_reg <= S_CORE;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (tick_reg)
                        begin
                            tick_reg  <= 1'b0;
                            state_reg <= S_CORE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    property p_emit_holds;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(etask_reg));
    endproperty
    a_emit_holds: assert property (p_emit_holds) else $error("result dropped");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        1'b1 |-> (count_reg <= (SW+1)'(TASK_SLOTS));
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("fifo count overflow");

    property p_dispatch_fills;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && kind_reg == mfts_pkg::EV_DISPATCH) |-> cvalid_reg[CW'(ecore_reg)];
    endproperty
    a_dispatch_fills: assert property (p_dispatch_fills) else $error("dispatch to empty core");

endmodule

[rtl/multicore_fcfs_rr_task_scheduler_unit.sv]
// Multicore task dispatcher, FCFS or round robin.
// Input channel (valid/ready): cmd admits a task, ticks the scheduler or
// reports one executed instruction of a core. Beats land in a four-entry
// command queue; the engine behind it takes one command at a time.
// Output channel (valid/ready): one result beat per event; last_event marks
// the final beat of a command. Admit and report (on a busy core) show their
// beat in the cycle after the engine takes the command from the queue; the
// engine takes the next command in the cycle after that beat is accepted.
// A tick walks every sleep slot, reading and then writing each one, then
// for each dispatched core reads the ready FIFO and shows a dispatch beat;
// a tick that dispatches nothing shows no beat.
// Configuration: cfg_we/cfg_index/cfg_data; the user must write it only while idle, the block does not enforce this.
// Reset (rst_n low) empties the queue, the ready FIFO, the sleep table and
// all cores, and restores the register defaults; no clearing pass is needed.
// When the receiver stalls, the current result beat holds and the engine
// waits; commands keep filling the queue until it is full.
module multicore_fcfs_rr_task_scheduler_unit
#(
    parameter int MAX_CORES  = mfts_pkg::MAX_CORES_DEF,
    parameter int TASK_SLOTS = mfts_pkg::TASK_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [5:0]  task_id,
    input  logic [2:0]  core_index,
    input  logic        task_done,
    input  logic        task_slept,
    input  logic [7:0]  sleep_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [2:0]  event_core,
    output logic [5:0]  event_task,
    output logic [31:0] executed_total,
    output logic        last_event,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    mfts_pkg::cmd_t in_cmd;
    mfts_pkg::cmd_t q_cmd;
    logic           q_valid;
    logic           q_ready;
    logic           policy_reg;
    logic [7:0]     quantum_reg;
    logic [3:0]     cores_reg;

    assign in_cmd = '{cmd: cmd, task_id: task_id, core_index: core_index,
                      task_done: task_done, task_slept: task_slept,
                      sleep_length: sleep_length};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= 1'b0;
            quantum_reg <= 8'd1;
            cores_reg   <= 4'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfts_pkg::REG_POLICY:  policy_reg  <= cfg_data[0];
                mfts_pkg::REG_QUANTUM: quantum_reg <= cfg_data;
                mfts_pkg::REG_CORES:   cores_reg   <= cfg_data[3:0];
                default:               policy_reg  <= policy_reg;
            endcase
        end
    end

    mfts_cmd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_cmd)
    );

    mfts_engine #(.MAX_CORES(MAX_CORES), .TASK_SLOTS(TASK_SLOTS)) u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd),
        .policy_mode    (policy_reg),
        .quantum_length (quantum_reg),
        .cores_in_use   (cores_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .event_core     (event_core),
        .event_task     (event_task),
        .executed_total (executed_total),
        .last_event     (last_event)
    );

endmodule
